// ----- rtl/core/uarttx_pkg.sv -----
// Shared constants and types for the FIFO-fed 8N1 UART transmitter.
package uarttx_pkg;

  // Transmit FIFO geometry.
  localparam int FIFO_DEPTH = 64;
  localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // Frame format and field widths.
  localparam int DATA_BITS = 8;
  localparam int BIDX_W    = 4;
  localparam int TPB_W     = 16;
  localparam int LVL_W     = 7;

  localparam logic [BIDX_W-1:0] BIT_STOP  = BIDX_W'(DATA_BITS);
  localparam logic [TPB_W-1:0]  TPB_RESET = 16'd1667;

  // Request kinds on the input channel.
  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // One result item as held in the output and skid registers.
  typedef struct packed {
    logic             tx_line;
    logic             accepted;
    logic             busy_res;
    logic [LVL_W-1:0] fifo_level;
  } result_t;

endpackage

// ----- rtl/core/uart_tx_fifo_8n1_core.sv -----
// Top level of the FIFO-fed 8N1 UART transmitter.
//
// Input channel (in_valid/in_ready): each request is either a push of
// in_data_byte into the transmit FIFO (in_mode 0) or one bit-timer tick
// (in_mode 1). Every request yields exactly one result on the output
// channel (out_valid/out_ready) with the line level, whether a pushed byte
// was stored, the busy flag and the FIFO fill level after that request.
// The configuration port (cfg_we/cfg_wdata) sets ticks_per_bit.
// Throughput is one request per clock cycle while in_ready is high; each
// result is registered. The FIFO bytes live in a RAM with a registered
// read; a popped byte is loaded into the shift register on the following
// cycle, or bypassed when it is pushed in the same cycle.
// An output register and a skid register decouple the channels: while the
// receiver stalls, one more request is taken into the skid register, then
// in_ready drops until the receiver drains it.
// Reset (rst_n low, synchronous) empties the FIFO, drives the line high,
// sets ticks_per_bit to 1667 and discards any pending result; in_ready is
// low while reset is held.
module uart_tx_fifo_8n1_core
  import uarttx_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_mode,
  input  logic [7:0]       in_data_byte,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_tx_line,
  output logic             out_accepted,
  output logic             out_busy_res,
  output logic [LVL_W-1:0] out_fifo_level,
  input  logic             cfg_we,
  input  logic [TPB_W-1:0] cfg_wdata
);

  // Architectural state.
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic [7:0]        shift_r, shift_nxt;
  logic              load_pend_r, load_pend_nxt;
  logic [BIDX_W-1:0] bit_idx_r, bit_idx_nxt;
  logic [TPB_W-1:0]  tick_r, tick_nxt;
  logic              sending_r, sending_nxt;
  logic              line_r, line_nxt;
  logic [TPB_W-1:0]  tpb_r;

  // Result buffering.
  result_t out_r, skid_r, res_nxt;
  logic    out_valid_r, skid_valid_r;

  // Handshake and datapath helpers.
  logic             in_fire, out_fire;
  logic             is_push, fifo_full, do_write, do_pop;
  logic             bypass;
  logic [7:0]       shift_cur, ram_rdata;
  logic [TPB_W-1:0] period, tick_inc;
  logic [CNT_W-1:0] fill_pushed;

  assign in_ready = rst_n && !skid_valid_r;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid_r && out_ready;

  // A byte fetched by the last pop arrives from the RAM this cycle.
  assign shift_cur = load_pend_r ? ram_rdata : shift_r;

  assign is_push     = (in_mode == MODE_PUSH);
  assign fifo_full   = (fill_r == CNT_W'(FIFO_DEPTH));
  assign do_write    = in_fire && is_push && !fifo_full;
  assign fill_pushed = fill_r + CNT_W'(do_write);
  assign period      = (tpb_r == '0) ? TPB_W'(1) : tpb_r;
  assign tick_inc    = tick_r + TPB_W'(1);

  // Next-state logic for one accepted request.
  always_comb begin
    rd_ptr_nxt    = rd_ptr_r;
    wr_ptr_nxt    = wr_ptr_r;
    fill_nxt      = fill_pushed;
    shift_nxt     = shift_cur;
    load_pend_nxt = 1'b0;
    bit_idx_nxt   = bit_idx_r;
    tick_nxt      = tick_r;
    sending_nxt   = sending_r;
    line_nxt      = line_r;
    do_pop        = 1'b0;

    if (do_write) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end

    if (in_fire) begin
      if (is_push) begin
        if (!sending_r && fill_pushed != '0) begin
          do_pop = 1'b1;
        end
      end else if (sending_r) begin
        if (tick_inc >= period) begin
          tick_nxt = '0;
          if (bit_idx_r < BIT_STOP) begin
            line_nxt    = shift_cur[bit_idx_r[2:0]];
            bit_idx_nxt = bit_idx_r + BIDX_W'(1);
          end else if (bit_idx_r == BIT_STOP) begin
            line_nxt    = 1'b1;
            bit_idx_nxt = bit_idx_r + BIDX_W'(1);
          end else begin
            bit_idx_nxt = '0;
            if (fill_r != '0) begin
              do_pop = 1'b1;
            end else begin
              sending_nxt = 1'b0;
              line_nxt    = 1'b1;
            end
          end
        end else begin
          tick_nxt = tick_inc;
        end
      end
    end

    // Pop the oldest byte and start its frame with the start bit.
    if (do_pop) begin
      rd_ptr_nxt  = (rd_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      fill_nxt    = fill_pushed - CNT_W'(1);
      line_nxt    = 1'b0;
      bit_idx_nxt = '0;
      tick_nxt    = '0;
      sending_nxt = 1'b1;
      if (bypass) begin
        shift_nxt = in_data_byte;
      end else begin
        load_pend_nxt = 1'b1;
      end
    end
  end

  // A pop of the entry being written this cycle takes the byte directly.
  assign bypass = do_write && (rd_ptr_r == wr_ptr_r);

  // Result fields for the accepted request.
  always_comb begin
    res_nxt.tx_line    = line_nxt;
    res_nxt.accepted   = do_write;
    res_nxt.busy_res   = sending_nxt;
    res_nxt.fifo_level = LVL_W'(fill_nxt);
  end

  // Transmit FIFO storage.
  uarttx_ram #(
    .WIDTH(8),
    .DEPTH(FIFO_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (do_write),
    .waddr(wr_ptr_r),
    .wdata(in_data_byte),
    .re   (do_pop && !bypass),
    .raddr(rd_ptr_r),
    .rdata(ram_rdata)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      fill_r      <= '0;
      shift_r     <= '0;
      load_pend_r <= 1'b0;
      bit_idx_r   <= '0;
      tick_r      <= '0;
      sending_r   <= 1'b0;
      line_r      <= 1'b1;
    end else begin
      rd_ptr_r    <= rd_ptr_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      fill_r      <= fill_nxt;
      shift_r     <= shift_nxt;
      load_pend_r <= load_pend_nxt;
      bit_idx_r   <= bit_idx_nxt;
      tick_r      <= tick_nxt;
      sending_r   <= sending_nxt;
      line_r      <= line_nxt;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpb_r <= TPB_RESET;
    end else if (cfg_we) begin
      tpb_r <= cfg_wdata;
    end
  end

  // Output register with a skid stage behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_fire) begin
      if (skid_valid_r) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end else if (in_fire) begin
        out_r <= res_nxt;
      end else begin
        out_valid_r <= 1'b0;
      end
    end else if (!out_valid_r) begin
      if (in_fire) begin
        out_r       <= res_nxt;
        out_valid_r <= 1'b1;
      end
    end else if (in_fire) begin
      skid_r       <= res_nxt;
      skid_valid_r <= 1'b1;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_tx_line    = out_r.tx_line;
  assign out_accepted   = out_r.accepted;
  assign out_busy_res   = out_r.busy_res;
  assign out_fifo_level = out_r.fifo_level;

  // The fill count never passes the FIFO depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(FIFO_DEPTH))
    else $error("FIFO fill count above depth");

  // An idle transmitter has nothing waiting and holds the line high.
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !sending_r |-> (fill_r == '0) && line_r)
    else $error("idle transmitter with bytes waiting or line low");

  // The skid register is only filled behind a held output register.
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register valid without output register");

  // A push into a full FIFO leaves the fill count unchanged.
  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && is_push && fifo_full) |=> (fill_r == $past(fill_r)))
    else $error("push into full FIFO changed fill count");

  // A pending RAM load only follows a pop that did not bypass.
  a_load_src: assert property (@(posedge clk) disable iff (!rst_n)
    load_pend_r |-> $past(do_pop) && !$past(bypass))
    else $error("RAM load without a preceding pop");

endmodule

// ----- rtl/core/uarttx_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module uarttx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data holds until the next enabled read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
